// ===== design/slc_pkg.sv =====
// Shared types and constants of the snooping LRU cache controller.
// Used by slc_set_ram, slc_way_select, slc_row_update and the top level; depends on nothing.

package slc_pkg;

   localparam int ADDR_W = 32;
   localparam int ID_W   = 4;
   localparam int CMD_W  = 4;
   localparam int ACT_W  = 3;

   localparam int DEF_WAYS       = 8;
   localparam int DEF_SETS       = 128;
   localparam int DEF_LINE_BYTES = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_CPU_READ   = 4'd0,
      CMD_CPU_WRITE  = 4'd1,
      CMD_FILL_CACHE = 4'd2,
      CMD_FILL_MEM   = 4'd3,
      CMD_FILL_WA    = 4'd4,
      CMD_WB_DONE    = 4'd5,
      CMD_INV_DONE   = 4'd6,
      CMD_SNOOP_RD   = 4'd7,
      CMD_SNOOP_INV  = 4'd8
   } cmd_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_BUS_READ   = 3'd0,
      ACT_CPU_RD_RSP = 3'd1,
      ACT_BUS_WA_RD  = 3'd2,
      ACT_INVALIDATE = 3'd3,
      ACT_WRITE_BACK = 3'd4,
      ACT_CPU_WR_RSP = 3'd5,
      ACT_SNOOP_RSP  = 3'd6,
      ACT_SNOOP_MISS = 3'd7
   } action_type;

   // Outcome of the tag lookup in one set.
   typedef struct packed {
      logic hit;           // some way holds the tag, valid or not
      logic hit_valid;     // the winning way is also valid
      logic victim_dirty;  // the replacement way is valid and dirty
   } lookup_type;

   // One result transaction.
   typedef struct packed {
      action_type        action;
      logic [ADDR_W-1:0] address;
      logic [ID_W-1:0]   target;
      logic              last;
   } rsp_type;

endpackage

// ===== design/snooping_lru_cache_controller_core.sv =====
// Top level of the snooping LRU cache controller (tag side, no line data).
// Depends on slc_pkg, slc_set_ram, slc_way_select and slc_row_update.

// Usage
// A request transaction (CPU access, fill or completion response, snoop) is
// taken at a rising edge where start is high and busy is low; req_cmd,
// req_address and req_requester are sampled at that edge. Each request gives
// zero, one or two result transactions on the rsp_ ports, each shown for
// exactly one cycle with rsp_valid high; rsp_last marks the final one.
// The receiver cannot stall the block, so results are never held back.
// The first result is registered at the end of the write cycle; a second result
// (a write-back ahead of a fill answer) waits in a pending register behind it.
// Each request reads its set's row from the set memory, evaluates the tags and
// ages, and writes the row back; the next request is taken during that write
// cycle, with the written row forwarded when both requests address the same set.
// csr_write_en loads csr_write_data as the cache id; the user must write it only
// while no request is in flight, as the block itself does not enforce this.
// Reset: after reset is released, a clearing pass walks the set memory one row
// a cycle to zero tags, valid and dirty bits and to set each way's age to its
// index. busy stays high during the pass.

module snooping_lru_cache_controller_core #(
   parameter int WAYS       = slc_pkg::DEF_WAYS,
   parameter int SETS       = slc_pkg::DEF_SETS,
   parameter int LINE_BYTES = slc_pkg::DEF_LINE_BYTES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [slc_pkg::CMD_W-1:0]    req_cmd,
   input  logic [slc_pkg::ADDR_W-1:0]   req_address,
   input  logic [slc_pkg::ID_W-1:0]     req_requester,
   output logic                         rsp_valid,
   output logic [slc_pkg::ACT_W-1:0]    rsp_action,
   output logic [slc_pkg::ADDR_W-1:0]   rsp_out_address,
   output logic [slc_pkg::ID_W-1:0]     rsp_target_id,
   output logic                         rsp_last,
   input  logic                         csr_write_en,
   input  logic [slc_pkg::ID_W-1:0]     csr_write_data
);

   // Address split. LINE_BYTES and SETS are powers of two.
   localparam int OFF_BITS = $clog2(LINE_BYTES);
   localparam int SET_BITS = $clog2(SETS);
   localparam int SETW     = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int TAGW     = slc_pkg::ADDR_W - OFF_BITS - SET_BITS;
   localparam int AGEW     = $clog2(WAYS);
   localparam int ROW_W    = WAYS * (TAGW + 2 + AGEW);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [SETW-1:0]            clr_cnt_ff;
   logic [slc_pkg::ID_W-1:0]   cache_id_ff;

   // Request being worked on.
   slc_pkg::cmd_type           cmd_ff;
   logic [slc_pkg::ADDR_W-1:0] addr_ff;
   logic [slc_pkg::ID_W-1:0]   req_id_ff;
   logic [SETW-1:0]            set_ff;
   logic [TAGW-1:0]            tag;

   // Forwarding of the row written in the cycle the next request was taken.
   logic                       fwd_ff;
   logic [ROW_W-1:0]           fwd_row_ff;

   // Row and lookup outcome registered at the end of evaluation.
   logic [ROW_W-1:0]           row_ff;
   slc_pkg::lookup_type        look_ff;
   logic [AGEW-1:0]            hit_way_ff;
   logic [AGEW-1:0]            victim_way_ff;

   // Result register and the pending second result.
   logic                       rsp_valid_ff;
   slc_pkg::rsp_type           rsp_ff;
   logic                       pend_valid_ff;
   slc_pkg::rsp_type           pend_ff;

   logic                       accept;
   logic [SETW-1:0]            req_set;
   logic [ROW_W-1:0]           ram_rd_data;
   logic                       ram_wr_en;
   logic [SETW-1:0]            ram_wr_addr;
   logic [ROW_W-1:0]           ram_wr_data;
   logic [ROW_W-1:0]           clear_row;
   logic [ROW_W-1:0]           cur_row;
   logic [ROW_W-1:0]           new_row;

   logic [WAYS-1:0][TAGW-1:0]  cur_tags,  row_tags,  new_tags,  clr_tags;
   logic [WAYS-1:0]            cur_valid, row_valid, new_valid;
   logic [WAYS-1:0]            cur_dirty, row_dirty, new_dirty;
   logic [WAYS-1:0][AGEW-1:0]  cur_ages,  row_ages,  new_ages,  clr_ages;

   slc_pkg::lookup_type        look;
   logic [AGEW-1:0]            hit_way;
   logic [AGEW-1:0]            victim_way;
   logic                       first_valid, second_valid;
   slc_pkg::rsp_type           first, second;

   // ---------------------------------------------------------------------
   // Handshake and address split.
   // ---------------------------------------------------------------------
   assign busy    = (state_ff == ST_CLEAR) || (state_ff == ST_EVAL);
   assign accept  = start && !busy;
   assign req_set = SETW'((req_address >> OFF_BITS) & slc_pkg::ADDR_W'(SETS - 1));
   assign tag     = TAGW'(addr_ff >> (OFF_BITS + SET_BITS));

   // ---------------------------------------------------------------------
   // Set memory: read on accept, write back in the write cycle or during the
   // clearing pass.
   // ---------------------------------------------------------------------
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         clr_tags[w] = '0;
         clr_ages[w] = AGEW'(w);
      end
   end

   assign clear_row   = {clr_tags, {WAYS{1'b0}}, {WAYS{1'b0}}, clr_ages};
   assign ram_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_cnt_ff : set_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? clear_row : new_row;

   slc_set_ram #(
      .DEPTH (SETS),
      .AW    (SETW),
      .DW    (ROW_W)
   ) u_set_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   // ---------------------------------------------------------------------
   // Evaluation: the memory read data, or the forwarded row when the previous
   // request wrote the same set in the cycle this one was taken.
   // ---------------------------------------------------------------------
   assign cur_row = fwd_ff ? fwd_row_ff : ram_rd_data;
   assign {cur_tags, cur_valid, cur_dirty, cur_ages} = cur_row;

   slc_way_select #(
      .WAYS (WAYS),
      .TAGW (TAGW),
      .AGEW (AGEW)
   ) u_way_select (
      .tags       (cur_tags),
      .valid      (cur_valid),
      .dirty      (cur_dirty),
      .ages       (cur_ages),
      .tag        (tag),
      .look       (look),
      .hit_way    (hit_way),
      .victim_way (victim_way)
   );

   // ---------------------------------------------------------------------
   // Write cycle: decode the command into results and the updated row.
   // ---------------------------------------------------------------------
   assign {row_tags, row_valid, row_dirty, row_ages} = row_ff;

   slc_row_update #(
      .WAYS     (WAYS),
      .TAGW     (TAGW),
      .AGEW     (AGEW),
      .SETW     (SETW),
      .SET_BITS (SET_BITS),
      .OFF_BITS (OFF_BITS)
   ) u_row_update (
      .cmd          (cmd_ff),
      .address      (addr_ff),
      .requester    (req_id_ff),
      .cache_id     (cache_id_ff),
      .set_idx      (set_ff),
      .tag          (tag),
      .tags         (row_tags),
      .valid        (row_valid),
      .dirty        (row_dirty),
      .ages         (row_ages),
      .look         (look_ff),
      .hit_way      (hit_way_ff),
      .victim_way   (victim_way_ff),
      .new_tags     (new_tags),
      .new_valid    (new_valid),
      .new_dirty    (new_dirty),
      .new_ages     (new_ages),
      .first_valid  (first_valid),
      .first        (first),
      .second_valid (second_valid),
      .second       (second)
   );

   assign new_row = {new_tags, new_valid, new_dirty, new_ages};

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == SETW'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = accept ? ST_EVAL : ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         cache_id_ff   <= '0;
         fwd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + SETW'(1);
         end
         if (csr_write_en) begin
            cache_id_ff <= csr_write_data;
         end
         if (accept) begin
            fwd_ff <= (state_ff == ST_WRITE) && (req_set == set_ff);
         end
         // A second result always follows its first in the next cycle.
         if (state_ff == ST_WRITE) begin
            rsp_valid_ff  <= first_valid;
            pend_valid_ff <= second_valid;
         end else begin
            rsp_valid_ff  <= pend_valid_ff;
            pend_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= slc_pkg::cmd_type'(req_cmd);
         addr_ff    <= req_address;
         req_id_ff  <= req_requester;
         set_ff     <= req_set;
         fwd_row_ff <= new_row;
      end
      if (state_ff == ST_EVAL) begin
         row_ff        <= cur_row;
         look_ff       <= look;
         hit_way_ff    <= hit_way;
         victim_way_ff <= victim_way;
      end
      if (state_ff == ST_WRITE) begin
         rsp_ff  <= first;
         pend_ff <= second;
      end else begin
         rsp_ff <= pend_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_ff.action;
   assign rsp_out_address = rsp_ff.address;
   assign rsp_target_id   = rsp_ff.target;
   assign rsp_last        = rsp_ff.last;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_clear_quiet : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("result transaction during the clearing pass");

   a_pair_closes : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |=> rsp_valid_ff && rsp_ff.last)
      else $error("first of two results not followed by the final one");

   a_eval_writes : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |=> state_ff == ST_WRITE && ram_wr_en)
      else $error("evaluated row not written back");

   a_fwd_source : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL && fwd_ff |-> $past(state_ff) == ST_WRITE)
      else $error("forwarded row used without an overlapping write");

   a_pend_origin : assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> $past(state_ff) == ST_WRITE)
      else $error("pending result not produced by a write cycle");

endmodule

// ===== design/slc_set_ram.sv =====
// Synchronous single-port-read, single-port-write memory holding one cache set per row.
// Depends on slc_pkg for the default depth; read data is registered.

module slc_set_ram #(
   parameter int DEPTH = slc_pkg::DEF_SETS,
   parameter int AW    = 7,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/slc_way_select.sv =====
// Tag compare and replacement choice over the ways of one set.
// Depends on slc_pkg for the lookup struct.

module slc_way_select #(
   parameter int WAYS = slc_pkg::DEF_WAYS,
   parameter int TAGW = 20,
   parameter int AGEW = 3
) (
   input  logic [WAYS-1:0][TAGW-1:0] tags,
   input  logic [WAYS-1:0]           valid,
   input  logic [WAYS-1:0]           dirty,
   input  logic [WAYS-1:0][AGEW-1:0] ages,
   input  logic [TAGW-1:0]           tag,
   output slc_pkg::lookup_type       look,
   output logic [AGEW-1:0]           hit_way,
   output logic [AGEW-1:0]           victim_way
);

   logic hit;
   logic found;

   // The highest matching way wins, so later ways override earlier ones.
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (tags[w] == tag) begin
            hit     = 1'b1;
            hit_way = AGEW'(w);
         end
      end
   end

   // Ages in a set always form a permutation, so the oldest way is the one
   // whose age is the maximum; the lowest such way is taken.
   always_comb begin
      found      = 1'b0;
      victim_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && ages[w] == AGEW'(WAYS - 1)) begin
            found      = 1'b1;
            victim_way = AGEW'(w);
         end
      end
   end

   assign look.hit          = hit;
   assign look.hit_valid    = hit & valid[hit_way];
   assign look.victim_dirty = valid[victim_way] & dirty[victim_way];

endmodule

// ===== design/slc_row_update.sv =====
// Command decode: result transactions and the next state of one set's row.
// Depends on slc_pkg for command, action, lookup and result types.

module slc_row_update #(
   parameter int WAYS     = slc_pkg::DEF_WAYS,
   parameter int TAGW     = 20,
   parameter int AGEW     = 3,
   parameter int SETW     = 7,
   parameter int SET_BITS = 7,
   parameter int OFF_BITS = 5
) (
   input  slc_pkg::cmd_type                  cmd,
   input  logic [slc_pkg::ADDR_W-1:0]        address,
   input  logic [slc_pkg::ID_W-1:0]          requester,
   input  logic [slc_pkg::ID_W-1:0]          cache_id,
   input  logic [SETW-1:0]                   set_idx,
   input  logic [TAGW-1:0]                   tag,
   input  logic [WAYS-1:0][TAGW-1:0]         tags,
   input  logic [WAYS-1:0]                   valid,
   input  logic [WAYS-1:0]                   dirty,
   input  logic [WAYS-1:0][AGEW-1:0]         ages,
   input  slc_pkg::lookup_type               look,
   input  logic [AGEW-1:0]                   hit_way,
   input  logic [AGEW-1:0]                   victim_way,
   output logic [WAYS-1:0][TAGW-1:0]         new_tags,
   output logic [WAYS-1:0]                   new_valid,
   output logic [WAYS-1:0]                   new_dirty,
   output logic [WAYS-1:0][AGEW-1:0]         new_ages,
   output logic                              first_valid,
   output slc_pkg::rsp_type                  first,
   output logic                              second_valid,
   output slc_pkg::rsp_type                  second
);

   logic                       do_install;
   logic                       do_clear;
   logic [AGEW-1:0]            inst_way;
   logic                       inst_dirty;
   logic [AGEW-1:0]            cur_age;
   logic [slc_pkg::ADDR_W-1:0] victim_addr;

   assign victim_addr = (slc_pkg::ADDR_W'(tags[victim_way]) << (OFF_BITS + SET_BITS))
                      | (slc_pkg::ADDR_W'(set_idx) << OFF_BITS);

   always_comb begin
      first_valid  = 1'b0;
      second_valid = 1'b0;
      first        = '{action: slc_pkg::ACT_BUS_READ, address: address,
                       target: cache_id, last: 1'b1};
      second       = first;
      do_install   = 1'b0;
      do_clear     = 1'b0;
      inst_way     = hit_way;
      inst_dirty   = 1'b0;

      unique case (cmd) inside
         slc_pkg::CMD_CPU_READ: begin
            first_valid  = 1'b1;
            first.action = look.hit_valid ? slc_pkg::ACT_CPU_RD_RSP : slc_pkg::ACT_BUS_READ;
         end
         slc_pkg::CMD_CPU_WRITE: begin
            first_valid = 1'b1;
            if (look.hit) begin
               do_install   = 1'b1;
               inst_dirty   = 1'b1;
               first.action = slc_pkg::ACT_INVALIDATE;
            end else begin
               first.action = slc_pkg::ACT_BUS_WA_RD;
            end
         end
         slc_pkg::CMD_FILL_CACHE, slc_pkg::CMD_FILL_MEM, slc_pkg::CMD_FILL_WA: begin
            do_install = 1'b1;
            inst_way   = victim_way;
            inst_dirty = (cmd != slc_pkg::CMD_FILL_MEM);
            first_valid = 1'b1;
            if (look.victim_dirty) begin
               // A dirty victim is written back before the fill completes.
               first.action   = slc_pkg::ACT_WRITE_BACK;
               first.address  = victim_addr;
               first.last     = 1'b0;
               second_valid   = 1'b1;
               second.action  = (cmd == slc_pkg::CMD_FILL_WA) ?
                                slc_pkg::ACT_INVALIDATE : slc_pkg::ACT_CPU_RD_RSP;
            end else begin
               first.action = (cmd == slc_pkg::CMD_FILL_WA) ?
                              slc_pkg::ACT_INVALIDATE : slc_pkg::ACT_CPU_RD_RSP;
            end
         end
         slc_pkg::CMD_WB_DONE, slc_pkg::CMD_INV_DONE: begin
            first_valid  = 1'b1;
            first.action = slc_pkg::ACT_CPU_WR_RSP;
         end
         slc_pkg::CMD_SNOOP_RD: begin
            first_valid  = 1'b1;
            first.action = look.hit_valid ? slc_pkg::ACT_SNOOP_RSP : slc_pkg::ACT_SNOOP_MISS;
            first.target = requester;
         end
         slc_pkg::CMD_SNOOP_INV: begin
            do_clear = look.hit;
         end
         default: begin
         end
      endcase
   end

   // Install and age update: ways younger than the touched way age by one.
   assign cur_age = ages[inst_way];

   always_comb begin
      new_tags  = tags;
      new_valid = valid;
      new_dirty = dirty;
      new_ages  = ages;
      if (do_install) begin
         new_tags[inst_way]  = tag;
         new_valid[inst_way] = 1'b1;
         new_dirty[inst_way] = inst_dirty;
         for (int w = 0; w < WAYS; w++) begin
            if (AGEW'(w) == inst_way) begin
               new_ages[w] = '0;
            end else if (ages[w] < cur_age) begin
               new_ages[w] = ages[w] + AGEW'(1);
            end
         end
      end
      if (do_clear) begin
         new_valid[hit_way] = 1'b0;
         new_dirty[hit_way] = 1'b0;
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for snooping_lru_cache_controller_core.
// Depends on slc_pkg and the controller RTL; it predicts every bus and CPU action
// from its own copy of the tag, valid, dirty and age state of all ways.

module testbench;

   // The block is built with its default geometry, and the predictor follows it.
   localparam int WAYS       = slc_pkg::DEF_WAYS;
   localparam int SETS       = slc_pkg::DEF_SETS;
   localparam int LINE_BYTES = slc_pkg::DEF_LINE_BYTES;
   localparam longint unsigned TAG_COUNT = 64'h1_0000_0000 / (LINE_BYTES * SETS);

   // Command codes 9 to 15 have no meaning; the block must drop them silently.
   localparam logic [slc_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 4'd9;
   localparam logic [slc_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 4'd15;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_LIMIT  = 200;
   localparam int DRAIN_CYCLES = 8;   // margin for a trailing request that gives no result
   localparam int HOT_SETS     = 5;
   localparam int HOT_TAGS     = 12;  // more tags than ways, so sets thrash

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [slc_pkg::CMD_W-1:0]    req_cmd = '0;
   logic [slc_pkg::ADDR_W-1:0]   req_address = '0;
   logic [slc_pkg::ID_W-1:0]     req_requester = '0;
   logic                         rsp_valid;
   logic [slc_pkg::ACT_W-1:0]    rsp_action;
   logic [slc_pkg::ADDR_W-1:0]   rsp_out_address;
   logic [slc_pkg::ID_W-1:0]     rsp_target_id;
   logic                         rsp_last;
   logic                         csr_write_en = 1'b0;
   logic [slc_pkg::ID_W-1:0]     csr_write_data = '0;

   snooping_lru_cache_controller_core #(
      .WAYS(WAYS),
      .SETS(SETS),
      .LINE_BYTES(LINE_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_address(req_address),
      .req_requester(req_requester),
      .rsp_valid(rsp_valid),
      .rsp_action(rsp_action),
      .rsp_out_address(rsp_out_address),
      .rsp_target_id(rsp_target_id),
      .rsp_last(rsp_last),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   // Shadow copy of the line state, indexed by set and way.
   int unsigned              line_tag   [SETS][WAYS];
   bit                       line_valid [SETS][WAYS];
   bit                       line_dirty [SETS][WAYS];
   int                       line_age   [SETS][WAYS];
   logic [slc_pkg::ID_W-1:0] model_cache_id;

   // Actions the block still owes, oldest first.
   slc_pkg::rsp_type         expected_actions[$];

   int              error_count = 0;
   int              cycle_count = 0;
   int              items_sent = 0;
   int              sender_idle_pct = 0;
   int unsigned     hot_sets[HOT_SETS];
   int unsigned     hot_tags[HOT_TAGS];

   initial begin
      forever #2 clock = ~clock;
   end

   // Every failure goes through here: one line is printed and the count goes up.
   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic int set_of(logic [slc_pkg::ADDR_W-1:0] addr);
      return int'((addr / LINE_BYTES) % SETS);
   endfunction

   function automatic int unsigned tag_of(logic [slc_pkg::ADDR_W-1:0] addr);
      return addr / (LINE_BYTES * SETS);
   endfunction

   // The lookup compares tags only. When more than one way holds the tag,
   // the last (highest) one found wins.
   function automatic int find_line(logic [slc_pkg::ADDR_W-1:0] addr);
      int s;
      int hit;
      s = set_of(addr);
      hit = -1;
      for (int w = 0; w < WAYS; w++)
         if (line_tag[s][w] == tag_of(addr))
            hit = w;
      return hit;
   endfunction

   function automatic bit line_usable(logic [slc_pkg::ADDR_W-1:0] addr);
      int hit;
      hit = find_line(addr);
      return hit >= 0 && line_valid[set_of(addr)][hit];
   endfunction

   // Replacement picks the oldest way; on equal ages the lower way stays chosen.
   function automatic int oldest_way(int s);
      int best;
      best = 0;
      for (int w = 1; w < WAYS; w++)
         if (line_age[s][w] > line_age[s][best])
            best = w;
      return best;
   endfunction

   function automatic void make_recent(int s, int way);
      int cur;
      cur = line_age[s][way];
      for (int w = 0; w < WAYS; w++)
         if (w != way && line_age[s][w] < cur)
            line_age[s][w]++;
      line_age[s][way] = 0;
   endfunction

   function automatic void install_line(int s, int way, int unsigned tag, bit dirty);
      line_tag[s][way]   = tag;
      line_valid[s][way] = 1'b1;
      line_dirty[s][way] = dirty;
      make_recent(s, way);
   endfunction

   function automatic void expect_action(slc_pkg::action_type act,
                                         logic [slc_pkg::ADDR_W-1:0] addr,
                                         logic [slc_pkg::ID_W-1:0] target, logic fin);
      slc_pkg::rsp_type r;
      r.action  = act;
      r.address = addr;
      r.target  = target;
      r.last    = fin;
      expected_actions.insert(expected_actions.size(), r);
   endfunction

   function automatic void clear_line_model();
      for (int s = 0; s < SETS; s++)
         for (int w = 0; w < WAYS; w++) begin
            line_tag[s][w]   = 0;
            line_valid[s][w] = 1'b0;
            line_dirty[s][w] = 1'b0;
            line_age[s][w]   = w;
         end
      model_cache_id = '0;
   endfunction

   // Works out the actions one accepted request causes and updates the
   // shadow state exactly as the block is meant to.
   function automatic void predict_cache_actions(logic [slc_pkg::CMD_W-1:0] cmd,
                                                 logic [slc_pkg::ADDR_W-1:0] addr,
                                                 logic [slc_pkg::ID_W-1:0] who);
      int          s;
      int unsigned t;
      int          hit;
      bit          hv;
      int          v;
      logic [slc_pkg::ADDR_W-1:0] victim_addr;
      s   = set_of(addr);
      t   = tag_of(addr);
      hit = find_line(addr);
      hv  = line_usable(addr);
      case (cmd) inside
         slc_pkg::CMD_CPU_READ: begin
            // A read never changes the ages, hit or miss.
            expect_action(hv ? slc_pkg::ACT_CPU_RD_RSP : slc_pkg::ACT_BUS_READ, addr,
                          model_cache_id, 1'b1);
         end
         slc_pkg::CMD_CPU_WRITE: begin
            if (hit < 0) begin
               expect_action(slc_pkg::ACT_BUS_WA_RD, addr, model_cache_id, 1'b1);
            end else begin
               // A tag match counts even on an invalid way, which comes back valid.
               install_line(s, hit, t, 1'b1);
               expect_action(slc_pkg::ACT_INVALIDATE, addr, model_cache_id, 1'b1);
            end
         end
         slc_pkg::CMD_FILL_CACHE, slc_pkg::CMD_FILL_MEM, slc_pkg::CMD_FILL_WA: begin
            v = oldest_way(s);
            if (line_valid[s][v] && line_dirty[s][v]) begin
               // The write-back names the victim's own line, not the request.
               victim_addr = slc_pkg::ADDR_W'((longint'(line_tag[s][v]) * SETS + s)
                                              * LINE_BYTES);
               expect_action(slc_pkg::ACT_WRITE_BACK, victim_addr, model_cache_id, 1'b0);
            end
            install_line(s, v, t, cmd != slc_pkg::CMD_FILL_MEM);
            expect_action(cmd == slc_pkg::CMD_FILL_WA ? slc_pkg::ACT_INVALIDATE
                                                      : slc_pkg::ACT_CPU_RD_RSP,
                          addr, model_cache_id, 1'b1);
         end
         slc_pkg::CMD_WB_DONE, slc_pkg::CMD_INV_DONE: begin
            expect_action(slc_pkg::ACT_CPU_WR_RSP, addr, model_cache_id, 1'b1);
         end
         slc_pkg::CMD_SNOOP_RD: begin
            expect_action(hv ? slc_pkg::ACT_SNOOP_RSP : slc_pkg::ACT_SNOOP_MISS, addr,
                          who, 1'b1);
         end
         slc_pkg::CMD_SNOOP_INV: begin
            if (hit >= 0) begin
               line_valid[s][hit] = 1'b0;
               line_dirty[s][hit] = 1'b0;
            end
         end
         default: begin
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   // A result is taken at the edge that ends its one-cycle strobe, so the
   // outputs are sampled right at that edge, before the block updates them.
   always @(posedge clock) begin
      slc_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_actions.size() == 0) begin
            report_mismatch($sformatf("unexpected action %0d address %h target %0d",
                                      rsp_action, rsp_out_address, rsp_target_id));
         end else begin
            want = expected_actions[0];
            expected_actions.delete(0);
            if (rsp_action !== want.action)
               report_mismatch($sformatf("action %0d, expected %0d (address %h)",
                                         rsp_action, want.action, want.address));
            if (rsp_out_address !== want.address)
               report_mismatch($sformatf("address %h, expected %h (action %0d)",
                                         rsp_out_address, want.address, want.action));
            if (rsp_target_id !== want.target)
               report_mismatch($sformatf("target %0d, expected %0d (address %h)",
                                         rsp_target_id, want.target, want.address));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, expected %b (address %h)",
                                         rsp_last, want.last, want.address));
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Presents one request transaction and holds it until the block takes it.
   // Start is left high afterwards so that back-to-back requests keep it
   // asserted; it only drops when the sender idles or drains.
   task automatic send_request(input logic [slc_pkg::CMD_W-1:0] cmd,
                               input logic [slc_pkg::ADDR_W-1:0] addr,
                               input logic [slc_pkg::ID_W-1:0] who);
      if ($urandom_range(99, 0) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(5, 1)) @(posedge clock);
      end
      req_cmd       <= cmd;
      req_address   <= addr;
      req_requester <= who;
      start         <= 1'b1;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      predict_cache_actions(cmd, addr, who);
      if (cmd <= slc_pkg::CMD_SNOOP_INV)
         items_sent++;
   endtask

   // Stops sending and waits until every owed result has come, plus a few
   // cycles for a trailing snoop invalidate, which gives no result.
   task automatic wait_for_idle();
      int spins;
      start <= 1'b0;
      spins = 0;
      while (expected_actions.size() != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_actions.size() != 0) begin
         report_mismatch($sformatf("%0d expected actions never arrived",
                                   expected_actions.size()));
         expected_actions.delete();
      end
   endtask

   // The cache id is only changed while nothing is in flight.
   task automatic write_cache_id(input logic [slc_pkg::ID_W-1:0] value);
      wait_for_idle();
      while (busy !== 1'b0)
         @(posedge clock);
      csr_write_data <= value;
      csr_write_en   <= 1'b1;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      model_cache_id = value;
   endtask

   // Random traffic works on a few sets and a dozen tags, so that lines hit,
   // get evicted dirty and are snooped away. Set and tag extremes are always
   // in the pool; a tenth of the addresses are fully random.
   function automatic void choose_hot_lines();
      hot_sets[0] = 0;
      hot_sets[1] = SETS - 1;
      for (int i = 2; i < HOT_SETS; i++)
         hot_sets[i] = $urandom_range(SETS - 1, 0);
      hot_tags[0] = 0;
      hot_tags[1] = 32'(TAG_COUNT - 1);
      for (int i = 2; i < HOT_TAGS; i++)
         hot_tags[i] = $urandom_range(32'(TAG_COUNT - 1), 0);
   endfunction

   function automatic logic [slc_pkg::ADDR_W-1:0] pick_address();
      longint unsigned t;
      longint unsigned s;
      if ($urandom_range(99, 0) < 10)
         return $urandom;
      t = hot_tags[$urandom_range(HOT_TAGS - 1, 0)];
      s = hot_sets[$urandom_range(HOT_SETS - 1, 0)];
      return slc_pkg::ADDR_W'((t * SETS + s) * LINE_BYTES
                              + $urandom_range(LINE_BYTES - 1, 0));
   endfunction

   // A well-formed CPU access as the rest of the system would play it: a
   // read miss is followed by its fill, a write miss by its write-allocate
   // fill and the invalidate completion, a write hit by a completion.
   task automatic run_access_sequence();
      logic [slc_pkg::ADDR_W-1:0] addr;
      logic [slc_pkg::ID_W-1:0]   who;
      addr = pick_address();
      who  = slc_pkg::ID_W'($urandom_range(15, 0));
      if ($urandom_range(1, 0) == 0) begin
         send_request(slc_pkg::CMD_CPU_READ, addr, who);
         if (!line_usable(addr))
            send_request($urandom_range(1, 0) ? slc_pkg::CMD_FILL_CACHE
                                              : slc_pkg::CMD_FILL_MEM, addr, who);
      end else if (find_line(addr) < 0) begin
         send_request(slc_pkg::CMD_CPU_WRITE, addr, who);
         send_request(slc_pkg::CMD_FILL_WA, addr, who);
         send_request(slc_pkg::CMD_INV_DONE, addr, who);
      end else begin
         send_request(slc_pkg::CMD_CPU_WRITE, addr, who);
         send_request($urandom_range(1, 0) ? slc_pkg::CMD_INV_DONE
                                           : slc_pkg::CMD_WB_DONE, addr, who);
      end
   endtask

   // Snoops from other caches, stray responses and plain garbage.
   task automatic send_noise();
      int r;
      r = $urandom_range(99, 0);
      if (r < 35)
         send_request(slc_pkg::CMD_SNOOP_RD, pick_address(),
                      slc_pkg::ID_W'($urandom_range(15, 0)));
      else if (r < 65)
         send_request(slc_pkg::CMD_SNOOP_INV, pick_address(),
                      slc_pkg::ID_W'($urandom_range(15, 0)));
      else if (r < 80)
         send_request(slc_pkg::CMD_W'($urandom_range((1 << slc_pkg::CMD_W) - 1, 0)),
                      $urandom, slc_pkg::ID_W'($urandom_range(15, 0)));
      else
         send_request(slc_pkg::CMD_W'($urandom_range(int'(slc_pkg::CMD_INV_DONE),
                                                     int'(slc_pkg::CMD_FILL_CACHE))),
                      pick_address(), slc_pkg::ID_W'($urandom_range(15, 0)));
   endtask

   task automatic run_traffic(input int count);
      int target;
      choose_hot_lines();
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(99, 0) < 65)
            run_access_sequence();
         else
            send_noise();
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-picked corner cases with the sender never idling.
   task automatic test_directed_cases();
      logic [slc_pkg::ADDR_W-1:0] top;
      top = '1;
      sender_idle_pct = 0;
      // After reset every way holds tag 0 but none is valid: the read misses,
      // while the write matches (the highest way) and revalidates it.
      send_request(slc_pkg::CMD_CPU_READ, '0, '0);
      send_request(slc_pkg::CMD_CPU_WRITE, 32'h0000_001F, '1);
      send_request(slc_pkg::CMD_CPU_READ, '0, '0);
      write_cache_id('1);
      send_request(slc_pkg::CMD_SNOOP_RD, 32'h0000_0010, 4'h5);
      // A snoop carrying this cache's own id is treated like any other.
      send_request(slc_pkg::CMD_SNOOP_INV, '0, model_cache_id);
      send_request(slc_pkg::CMD_SNOOP_RD, '0, 4'hA);
      // The tag still matches the invalidated way, so the write hits it.
      send_request(slc_pkg::CMD_CPU_WRITE, '0, '0);
      // Top of the address space: write miss, then a dirty write-allocate
      // fill; a full round of fills in that set evicts it with a write-back.
      send_request(slc_pkg::CMD_CPU_WRITE, top, '0);
      send_request(slc_pkg::CMD_FILL_WA, top, '0);
      for (int k = 1; k <= WAYS; k++)
         send_request(k % 2 ? slc_pkg::CMD_FILL_CACHE : slc_pkg::CMD_FILL_MEM,
                      top - slc_pkg::ADDR_W'(k * LINE_BYTES * SETS), 4'h3);
      send_request(slc_pkg::CMD_WB_DONE, top, '0);
      send_request(slc_pkg::CMD_INV_DONE, '0, '1);
      // Undefined commands produce nothing and leave the state alone.
      send_request(CMD_UNUSED_FIRST, top, '1);
      send_request(CMD_UNUSED_LAST, '0, '0);
   endtask

   // Requests back to back, so that neighbors often share a set and the
   // block must forward its own row write.
   task automatic test_back_to_back_traffic();
      write_cache_id(slc_pkg::ID_W'($urandom_range(14, 1)));
      sender_idle_pct = 0;
      run_traffic(340);
   endtask

   // The sender idles before most requests; its random gaps make requests arrive
   // both while the block writes a row back and after it has gone idle.
   task automatic test_sparse_sender();
      write_cache_id('0);
      sender_idle_pct = 58;
      run_traffic(320);
   endtask

   task automatic test_occasional_gaps();
      write_cache_id(slc_pkg::ID_W'($urandom_range(15, 0)));
      sender_idle_pct = 13;
      run_traffic(320);
   endtask

   initial begin
      clear_line_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // The first write also waits out the clearing pass after reset.
      write_cache_id('0);
      test_directed_cases();
      test_back_to_back_traffic();
      test_sparse_sender();
      test_occasional_gaps();
      wait_for_idle();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== snooping_lru_cache_controller_core.f =====
design/slc_pkg.sv
design/slc_set_ram.sv
design/slc_way_select.sv
design/slc_row_update.sv
design/snooping_lru_cache_controller_core.sv
tb/sv/testbench.sv
